### rtl/jts_pkg.sv
package jts_pkg;

    // Offset and line counter widths.
    localparam int OFFSET_BITS = 32;
    localparam int LINE_BITS   = 32;

    // Width of the offset and line fields on the result channel.
    localparam int FIELD_W = 32;

    // One byte yields at most three token records.
    localparam int MAX_REC   = 3;
    localparam int REC_IDX_W = $clog2(MAX_REC);
    localparam int REC_CNT_W = $clog2(MAX_REC + 1);

    // Depth of the record queue between front and back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Characters that the scanner recognizes.
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef logic [OFFSET_BITS-1:0] t_ofs;
    typedef logic [LINE_BITS-1:0]   t_line;

    // Scan modes.
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_MINUS = 3'd1,
        MODE_INT   = 3'd2,
        MODE_DOT   = 3'd3,
        MODE_FRAC  = 3'd4,
        MODE_STR   = 3'd5
    } t_mode;

    // Token kinds as they appear on the result channel.
    typedef enum logic [3:0] {
        KIND_LBRACE  = 4'd0,
        KIND_RBRACE  = 4'd1,
        KIND_LBRACK  = 4'd2,
        KIND_RBRACK  = 4'd3,
        KIND_COMMA   = 4'd4,
        KIND_COLON   = 4'd5,
        KIND_STRING  = 4'd6,
        KIND_INT     = 4'd7,
        KIND_REAL    = 4'd8,
        KIND_UNKNOWN = 4'd9,
        KIND_UNTERM  = 4'd10
    } t_kind;

    // One token record.
    typedef struct packed {
        t_kind kind;
        t_ofs  start;
        t_ofs  len;
        t_line line;
    } t_rec;

    // All records caused by one byte, oldest in slot zero.
    typedef struct packed {
        logic [REC_CNT_W-1:0]    cnt;
        t_rec [MAX_REC-1:0]      rec;
    } t_bundle;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### rtl/jts_if.sv
// Byte stream into the scanner.
interface jts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

// Token records out of the scanner.
interface jts_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic [31:0] line_number;
    logic        run_end;

    modport source (
        output valid, output token_kind, output token_start, output token_length,
        output line_number, output run_end, input ready
    );
    modport sink (
        input valid, input token_kind, input token_start, input token_length,
        input line_number, input run_end, output ready
    );
endinterface

### rtl/jts_front.sv
module jts_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  jts_pkg::t_q_stat  i_q_stat,
    output logic              o_ready,
    output logic              o_push,
    output jts_pkg::t_bundle  o_bundle
);

    // Scanner state.
    jts_pkg::t_mode r_mode;
    jts_pkg::t_ofs  r_off;
    jts_pkg::t_line r_line;
    jts_pkg::t_ofs  r_tb;

    jts_pkg::t_mode n_mode;
    jts_pkg::t_ofs  n_off;
    jts_pkg::t_line n_line;
    jts_pkg::t_ofs  n_tb;

    // Fresh scan of the byte from the idle mode.
    logic           f_emit;
    jts_pkg::t_rec  f_rec;
    jts_pkg::t_mode f_mode;
    logic           f_tb;
    logic           f_nl;

    // Records closed by the open token, ahead of any fresh record.
    jts_pkg::t_rec                   pre0;
    jts_pkg::t_rec                   pre1;
    logic [jts_pkg::REC_CNT_W-1:0]   pre_cnt;
    logic                            use_fresh;
    jts_pkg::t_mode                  c_mode;
    logic                            c_nl;

    logic           accept;
    logic           dig;
    jts_pkg::t_ofs  nxt;
    jts_pkg::t_ofs  prv;
    jts_pkg::t_ofs  first;
    jts_pkg::t_ofs  one;
    jts_pkg::t_line line_up;

    function automatic jts_pkg::t_rec mk(jts_pkg::t_kind k, jts_pkg::t_ofs s,
                                         jts_pkg::t_ofs l, jts_pkg::t_line ln);
        jts_pkg::t_rec r;
        r.kind  = k;
        r.start = s;
        r.len   = l;
        r.line  = ln;
        return r;
    endfunction

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    assign dig     = (i_byte >= jts_pkg::CH_ZERO) && (i_byte <= jts_pkg::CH_NINE);
    assign one     = jts_pkg::t_ofs'(1);
    assign nxt     = r_off + one;
    assign prv     = r_off - one;
    assign first   = r_tb + one;
    assign line_up = r_line + jts_pkg::t_line'(1);

    // Classify the byte as if no token were open.
    always_comb begin
        f_emit = 1'b0;
        f_rec  = mk(jts_pkg::KIND_UNKNOWN, r_off, one, r_line);
        f_mode = jts_pkg::MODE_IDLE;
        f_tb   = 1'b0;
        f_nl   = 1'b0;
        priority if (i_byte == jts_pkg::CH_LBRACE) begin
            f_emit     = 1'b1;
            f_rec.kind = jts_pkg::KIND_LBRACE;
        end else if (i_byte == jts_pkg::CH_RBRACE) begin
            f_emit     = 1'b1;
            f_rec.kind = jts_pkg::KIND_RBRACE;
        end else if (i_byte == jts_pkg::CH_LBRACK) begin
            f_emit     = 1'b1;
            f_rec.kind = jts_pkg::KIND_LBRACK;
        end else if (i_byte == jts_pkg::CH_RBRACK) begin
            f_emit     = 1'b1;
            f_rec.kind = jts_pkg::KIND_RBRACK;
        end else if (i_byte == jts_pkg::CH_COMMA) begin
            f_emit     = 1'b1;
            f_rec.kind = jts_pkg::KIND_COMMA;
        end else if (i_byte == jts_pkg::CH_COLON) begin
            f_emit     = 1'b1;
            f_rec.kind = jts_pkg::KIND_COLON;
        end else if (i_byte == jts_pkg::CH_QUOTE) begin
            f_tb = 1'b1;
            if (i_last) begin
                f_emit = 1'b1;
                f_rec  = mk(jts_pkg::KIND_UNTERM, nxt, '0, r_line);
            end else begin
                f_mode = jts_pkg::MODE_STR;
            end
        end else if (i_byte == jts_pkg::CH_NEWLINE) begin
            f_nl = 1'b1;
        end else if (i_byte == jts_pkg::CH_MINUS) begin
            f_tb = 1'b1;
            if (i_last) begin
                f_emit = 1'b1;
            end else begin
                f_mode = jts_pkg::MODE_MINUS;
            end
        end else if (dig) begin
            f_tb = 1'b1;
            if (i_last) begin
                f_emit     = 1'b1;
                f_rec.kind = jts_pkg::KIND_INT;
            end else begin
                f_mode = jts_pkg::MODE_INT;
            end
        end else begin
            f_emit = 1'b1;
        end
    end

    // Continue or close the open token.
    always_comb begin
        pre0      = mk(jts_pkg::KIND_INT, r_tb, nxt - r_tb, r_line);
        pre1      = mk(jts_pkg::KIND_UNKNOWN, r_off, one, r_line);
        pre_cnt   = '0;
        use_fresh = 1'b0;
        c_mode    = r_mode;
        c_nl      = 1'b0;
        unique case (r_mode)
            jts_pkg::MODE_MINUS: begin
                if (dig) begin
                    c_mode = jts_pkg::MODE_INT;
                    if (i_last) begin
                        pre_cnt = jts_pkg::REC_CNT_W'(1);
                    end
                end else begin
                    pre0      = mk(jts_pkg::KIND_UNKNOWN, r_tb, one, r_line);
                    pre_cnt   = jts_pkg::REC_CNT_W'(1);
                    use_fresh = 1'b1;
                end
            end
            jts_pkg::MODE_INT: begin
                if (dig) begin
                    if (i_last) begin
                        pre_cnt = jts_pkg::REC_CNT_W'(1);
                    end
                end else if (i_byte == jts_pkg::CH_DOT) begin
                    if (i_last) begin
                        // Integer, then the trailing dot on its own.
                        pre0    = mk(jts_pkg::KIND_INT, r_tb, r_off - r_tb, r_line);
                        pre_cnt = jts_pkg::REC_CNT_W'(2);
                    end else begin
                        c_mode = jts_pkg::MODE_DOT;
                    end
                end else begin
                    pre0      = mk(jts_pkg::KIND_INT, r_tb, r_off - r_tb, r_line);
                    pre_cnt   = jts_pkg::REC_CNT_W'(1);
                    use_fresh = 1'b1;
                end
            end
            jts_pkg::MODE_DOT: begin
                if (dig) begin
                    c_mode = jts_pkg::MODE_FRAC;
                    if (i_last) begin
                        pre0    = mk(jts_pkg::KIND_REAL, r_tb, nxt - r_tb, r_line);
                        pre_cnt = jts_pkg::REC_CNT_W'(1);
                    end
                end else begin
                    // A dot with no fraction: integer, dot, then this byte scanned afresh.
                    pre0      = mk(jts_pkg::KIND_INT, r_tb, prv - r_tb, r_line);
                    pre1      = mk(jts_pkg::KIND_UNKNOWN, prv, one, r_line);
                    pre_cnt   = jts_pkg::REC_CNT_W'(2);
                    use_fresh = 1'b1;
                end
            end
            jts_pkg::MODE_FRAC: begin
                if (dig) begin
                    if (i_last) begin
                        pre0    = mk(jts_pkg::KIND_REAL, r_tb, nxt - r_tb, r_line);
                        pre_cnt = jts_pkg::REC_CNT_W'(1);
                    end
                end else begin
                    pre0      = mk(jts_pkg::KIND_REAL, r_tb, r_off - r_tb, r_line);
                    pre_cnt   = jts_pkg::REC_CNT_W'(1);
                    use_fresh = 1'b1;
                end
            end
            jts_pkg::MODE_STR: begin
                if (i_byte == jts_pkg::CH_QUOTE) begin
                    pre0    = mk(jts_pkg::KIND_STRING, first, r_off - first, r_line);
                    pre_cnt = jts_pkg::REC_CNT_W'(1);
                    c_mode  = jts_pkg::MODE_IDLE;
                end else begin
                    c_nl = (i_byte == jts_pkg::CH_NEWLINE);
                    if (i_last) begin
                        // The newline inside the string counts before the report.
                        pre0 = mk(jts_pkg::KIND_UNTERM, first, nxt - first,
                                  c_nl ? line_up : r_line);
                        pre_cnt = jts_pkg::REC_CNT_W'(1);
                    end
                end
            end
            default: begin
                use_fresh = 1'b1;
            end
        endcase
    end

    // Assemble the bundle and the next state.
    always_comb begin
        o_bundle.cnt    = pre_cnt + jts_pkg::REC_CNT_W'(use_fresh && f_emit);
        o_bundle.rec[0] = (pre_cnt != '0) ? pre0 : f_rec;
        o_bundle.rec[1] = (pre_cnt == jts_pkg::REC_CNT_W'(2)) ? pre1 : f_rec;
        o_bundle.rec[2] = f_rec;

        n_mode = use_fresh ? f_mode : c_mode;
        n_tb   = (use_fresh && f_tb) ? r_off : r_tb;
        n_line = ((use_fresh && f_nl) || c_nl) ? line_up : r_line;
        n_off  = nxt;
        if (i_last) begin
            n_mode = jts_pkg::MODE_IDLE;
            n_tb   = '0;
            n_line = '0;
            n_off  = '0;
        end
    end

    assign o_push = accept && (o_bundle.cnt != '0);

    // State registers, advanced on every accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jts_pkg::MODE_IDLE;
            r_off  <= '0;
            r_line <= '0;
            r_tb   <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_off  <= n_off;
            r_line <= n_line;
            r_tb   <= n_tb;
        end
    end

endmodule

### rtl/jts_fifo.sv
module jts_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  jts_pkg::t_bundle  i_bundle,
    input  logic              i_pop,
    output jts_pkg::t_q_stat  o_stat,
    output jts_pkg::t_bundle  o_bundle
);

    // Small register queue of bundles.
    jts_pkg::t_bundle                 r_mem [jts_pkg::FIFO_DEPTH];
    logic [jts_pkg::FIFO_PTR_W-1:0]   r_wr;
    logic [jts_pkg::FIFO_PTR_W-1:0]   r_rd;
    logic [jts_pkg::FIFO_CNT_W-1:0]   r_cnt;

    logic do_push;
    logic do_pop;

    function automatic logic [jts_pkg::FIFO_PTR_W-1:0] bump(
        logic [jts_pkg::FIFO_PTR_W-1:0] ptr);
        if (ptr == jts_pkg::FIFO_PTR_W'(jts_pkg::FIFO_DEPTH - 1)) begin
            return '0;
        end
        return ptr + jts_pkg::FIFO_PTR_W'(1);
    endfunction

    assign o_stat.full  = (r_cnt == jts_pkg::FIFO_CNT_W'(jts_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_bundle     = r_mem[r_rd];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= bump(r_wr);
            end
            if (do_pop) begin
                r_rd <= bump(r_rd);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + jts_pkg::FIFO_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - jts_pkg::FIFO_CNT_W'(1);
            end
        end
    end

endmodule

### rtl/jts_back.sv
module jts_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  jts_pkg::t_q_stat  i_q_stat,
    input  jts_pkg::t_bundle  i_bundle,
    output logic              o_pop,
    jts_token_if.source       o_token
);

    // Output register.
    logic                 r_valid;
    jts_pkg::t_rec        r_rec;
    logic                 r_run_end;

    // Slot of the next record within the head bundle.
    logic [jts_pkg::REC_IDX_W-1:0] r_idx;

    logic          load;
    logic          is_last;
    jts_pkg::t_rec cur;

    assign load    = (!r_valid || o_token.ready) && !i_q_stat.empty;
    assign cur     = i_bundle.rec[r_idx];
    assign is_last = (jts_pkg::REC_CNT_W'(r_idx) + jts_pkg::REC_CNT_W'(1)) == i_bundle.cnt;
    assign o_pop   = load && is_last;

    // Control: valid flag and slot index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? '0 : r_idx + jts_pkg::REC_IDX_W'(1);
            end else if (o_token.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload of the output register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec     <= cur;
            r_run_end <= is_last;
        end
    end

    assign o_token.valid        = r_valid;
    assign o_token.token_kind   = r_rec.kind;
    assign o_token.token_start  = jts_pkg::FIELD_W'(r_rec.start);
    assign o_token.token_length = jts_pkg::FIELD_W'(r_rec.len);
    assign o_token.line_number  = jts_pkg::FIELD_W'(r_rec.line);
    assign o_token.run_end      = r_run_end;

endmodule

### rtl/json_token_scanner_unit.sv
// A token record goes into the queue and then into the output register after the byte
// that closes it is taken. Throughput: one byte per cycle while the queue is not full;
// records leave one per cycle while the receiver is ready; the queue holds four bundles.
// Reset (synchronous, active low) clears the scan mode, offset, line count and token start,
// empties the queue and drops the output valid.
module json_token_scanner_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jts_byte_if.sink    i_text,
    jts_token_if.source o_token
);

    jts_pkg::t_q_stat q_stat;
    jts_pkg::t_bundle push_bundle;
    jts_pkg::t_bundle head_bundle;
    logic             push;
    logic             pop;

    // Front: scans bytes and builds record bundles.
    jts_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_text.valid),
        .i_byte   (i_text.text_byte),
        .i_last   (i_text.end_of_text),
        .i_q_stat (q_stat),
        .o_ready  (i_text.ready),
        .o_push   (push),
        .o_bundle (push_bundle)
    );

    // Queue between front and back.
    jts_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .i_pop    (pop),
        .o_stat   (q_stat),
        .o_bundle (head_bundle)
    );

    // Back: sends the records of each bundle one transfer at a time.
    jts_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_bundle (head_bundle),
        .o_pop    (pop),
        .o_token  (o_token)
    );

`ifndef NO_ASSERTIONS
    // A bundle that enters the queue always carries at least one record.
    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (push_bundle.cnt != '0))
        else $error("empty bundle pushed");

    // While a run is unfinished its remaining records still sit in the queue.
    a_run_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_token.valid && !o_token.run_end) |-> !q_stat.empty)
        else $error("run cut short");

    // Only defined token kinds reach the output.
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_token.valid |-> (o_token.token_kind <= 4'(jts_pkg::KIND_UNTERM)))
        else $error("bad token kind");

    // A pop never happens on an empty queue.
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop on empty queue");
`endif

endmodule
